FILE: sv/bmpdb_pkg.sv
`timescale 1ns / 1ps

package bmpdb_pkg;

    // Screen geometry and source limits
    localparam int SCREEN_WIDTH   = 800;
    localparam int SCREEN_HEIGHT  = 480;
    localparam int MAX_IMAGE_SIDE = 4096;
    localparam int MAX_STEP       = 64;

    // Field and counter widths
    localparam int XO_W    = 10;
    localparam int YO_W    = 9;
    localparam int SIDE_W  = 13;
    localparam int STEP_W  = 7;
    localparam int COL_W   = 12;
    localparam int PHASE_W = 6;
    localparam int PIX_W   = 24;
    localparam int ADDR_W  = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Restoring divider: one quotient bit per step
    localparam int DIV_STEPS = COL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHRINK_FACTOR = 3'd4;

    // Pixel handed from the sequencer to the output stage
    typedef struct packed {
        logic               fire;
        logic [PIX_W-1:0]   pixel;
        logic [COL_W-1:0]   target_column;
        logic [COL_W-1:0]   target_row;
    } emit_req_t;

    // Divider status back to the sequencer
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [COL_W-1:0]   quotient;
        logic [PHASE_W-1:0] remainder;
    } div_res_t;

    // Zero reads as one, oversized reads as the largest side
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (v > SIDE_W'(MAX_IMAGE_SIDE)) begin
            r = SIDE_W'(MAX_IMAGE_SIDE);
        end
        return r;
    endfunction

    // Zero step reads as one, oversized as the largest step
    function automatic logic [STEP_W-1:0] eff_step(input logic [STEP_W-1:0] v);
        logic [STEP_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = STEP_W'(1);
        end else if (v > STEP_W'(MAX_STEP)) begin
            r = STEP_W'(MAX_STEP);
        end
        return r;
    endfunction

endpackage

FILE: sv/bmp_decimating_blit_core.sv
`timescale 1ns / 1ps

// BMP decimating blit: takes 24-bit BMP pixels in file order (rows bottom-up,
// blue byte first) on the s_ channel and emits framebuffer writes on the m_
// channel: the pixel word (red in 23:16) and its word address on an 800 x 480
// screen. Every shrink_factor-th column and row is kept, the image is flipped
// upright, and pixels that land off-screen are dropped without a transfer.
// s_picture_start marks the first pixel of a picture.
// A pixel is accepted while idle; the sequencer then hands it to the output
// register once that is free, and s_ready stays low until it is idle again.
// A pixel with s_picture_start, and the last pixel of a picture, wait in a
// load state: the starting row phase and target row need a divide of
// (height - 1) by the step, done one quotient bit per cycle in a shared
// restoring divider. The user must write configuration through cfg_wr_en /
// cfg_index / cfg_wdata only while the block is idle; the block does not
// enforce this. Reset (aresetn low, synchronous) loads the default registers
// and zero counters, so a stream without picture start begins at the top row.
// When m_ready stays low the result is held in the output register; one more
// pixel is accepted, and the block then waits to emit it.
module bmp_decimating_blit_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [bmpdb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bmpdb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_blue_byte,
    input  logic [7:0]                          s_green_byte,
    input  logic [7:0]                          s_red_byte,
    input  logic                                s_picture_start,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bmpdb_pkg::PIX_W-1:0]         m_pixel_word,
    output logic [bmpdb_pkg::ADDR_W-1:0]        m_screen_address
);

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_LOAD_PRE = 2'd1;
    localparam logic [1:0] ST_EMIT     = 2'd2;
    localparam logic [1:0] ST_LOAD_POST = 2'd3;

    logic [1:0]                       state_reg, state_next;
    logic [bmpdb_pkg::XO_W-1:0]       x_origin_reg;
    logic [bmpdb_pkg::YO_W-1:0]       y_origin_reg;
    logic [bmpdb_pkg::SIDE_W-1:0]     width_reg;
    logic [bmpdb_pkg::SIDE_W-1:0]     height_reg;
    logic [bmpdb_pkg::STEP_W-1:0]     shrink_reg;
    logic [bmpdb_pkg::PIX_W-1:0]      pix_reg, pix_next;
    logic [bmpdb_pkg::COL_W-1:0]      src_col_reg, src_col_next;
    logic [bmpdb_pkg::COL_W-1:0]      rows_top_reg, rows_top_next;
    logic [bmpdb_pkg::PHASE_W-1:0]    col_phase_reg, col_phase_next;
    logic [bmpdb_pkg::PHASE_W-1:0]    row_phase_reg, row_phase_next;
    logic [bmpdb_pkg::COL_W-1:0]      tgt_col_reg, tgt_col_next;
    logic [bmpdb_pkg::COL_W-1:0]      tgt_row_reg, tgt_row_next;

    logic [bmpdb_pkg::STEP_W-1:0]     step;
    logic [bmpdb_pkg::SIDE_W-1:0]     width_eff;
    logic [bmpdb_pkg::SIDE_W-1:0]     height_eff;
    logic [bmpdb_pkg::COL_W-1:0]      last_row;
    logic                             col_end;
    logic                             col_wrap;
    logic                             div_start;
    logic                             out_free;
    bmpdb_pkg::div_res_t              div_res;
    bmpdb_pkg::emit_req_t             emit_req;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_origin_reg <= '0;
            y_origin_reg <= '0;
            width_reg    <= bmpdb_pkg::SIDE_W'(800);
            height_reg   <= bmpdb_pkg::SIDE_W'(480);
            shrink_reg   <= bmpdb_pkg::STEP_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bmpdb_pkg::REG_X_ORIGIN:      x_origin_reg <= cfg_wdata[bmpdb_pkg::XO_W-1:0];
                bmpdb_pkg::REG_Y_ORIGIN:      y_origin_reg <= cfg_wdata[bmpdb_pkg::YO_W-1:0];
                bmpdb_pkg::REG_IMAGE_WIDTH:   width_reg    <= cfg_wdata;
                bmpdb_pkg::REG_IMAGE_HEIGHT:  height_reg   <= cfg_wdata;
                bmpdb_pkg::REG_SHRINK_FACTOR: shrink_reg   <= cfg_wdata[bmpdb_pkg::STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Effective sizes and end-of-row tests
    always_comb begin
        step       = bmpdb_pkg::eff_step(shrink_reg);
        width_eff  = bmpdb_pkg::clamp_side(width_reg);
        height_eff = bmpdb_pkg::clamp_side(height_reg);
        last_row   = bmpdb_pkg::COL_W'(height_eff - 1'b1);
        col_end    = (bmpdb_pkg::SIDE_W'(src_col_reg) + 1'b1) >= width_eff;
        col_wrap   = (bmpdb_pkg::STEP_W'(col_phase_reg) + 1'b1) >= step;
    end

    // Sequencer and counter update
    always_comb begin
        state_next     = state_reg;
        pix_next       = pix_reg;
        src_col_next   = src_col_reg;
        rows_top_next  = rows_top_reg;
        col_phase_next = col_phase_reg;
        row_phase_next = row_phase_reg;
        tgt_col_next   = tgt_col_reg;
        tgt_row_next   = tgt_row_reg;
        div_start      = 1'b0;
        emit_req.fire          = 1'b0;
        emit_req.pixel         = pix_reg;
        emit_req.target_column = tgt_col_reg;
        emit_req.target_row    = tgt_row_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    pix_next = {s_red_byte, s_green_byte, s_blue_byte};
                    if (s_picture_start) begin
                        div_start  = 1'b1;
                        state_next = ST_LOAD_PRE;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_LOAD_PRE, ST_LOAD_POST: begin
                if (div_res.done) begin
                    src_col_next   = '0;
                    col_phase_next = '0;
                    tgt_col_next   = '0;
                    rows_top_next  = last_row;
                    row_phase_next = div_res.remainder;
                    tgt_row_next   = div_res.quotient;
                    state_next     = (state_reg == ST_LOAD_PRE) ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit_req.fire = (col_phase_reg == '0) && (row_phase_reg == '0);
                    state_next    = ST_IDLE;
                    if (col_end) begin
                        if (rows_top_reg == '0) begin
                            // wrap to a new picture
                            div_start  = 1'b1;
                            state_next = ST_LOAD_POST;
                        end else begin
                            src_col_next  = '0;
                            col_phase_next = '0;
                            tgt_col_next  = '0;
                            rows_top_next = rows_top_reg - 1'b1;
                            if (row_phase_reg == '0) begin
                                row_phase_next = bmpdb_pkg::PHASE_W'(step - 1'b1);
                                tgt_row_next   = tgt_row_reg - 1'b1;
                            end else begin
                                row_phase_next = row_phase_reg - 1'b1;
                            end
                        end
                    end else begin
                        src_col_next = src_col_reg + 1'b1;
                        if (col_wrap) begin
                            col_phase_next = '0;
                            tgt_col_next   = tgt_col_reg + 1'b1;
                        end else begin
                            col_phase_next = col_phase_reg + 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            src_col_reg   <= '0;
            rows_top_reg  <= '0;
            col_phase_reg <= '0;
            row_phase_reg <= '0;
            tgt_col_reg   <= '0;
            tgt_row_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            src_col_reg   <= src_col_next;
            rows_top_reg  <= rows_top_next;
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
            tgt_col_reg   <= tgt_col_next;
            tgt_row_reg   <= tgt_row_next;
        end
        pix_reg <= pix_next;
    end

    assign s_ready = (state_reg == ST_IDLE);

    bmpdb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (last_row),
        .divisor  (step),
        .res      (div_res)
    );

    bmpdb_emit u_emit (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .req              (emit_req),
        .x_origin         (x_origin_reg),
        .y_origin         (y_origin_reg),
        .out_free         (out_free),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pixel_word     (m_pixel_word),
        .m_screen_address (m_screen_address)
    );

`ifndef SYNTHESIS
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_res.busy)
        else $error("divider restarted while busy");

    a_start_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_picture_start) |=> (state_reg == ST_LOAD_PRE))
        else $error("picture start did not enter the load sequence");

    a_done_in_load: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == ST_LOAD_PRE || state_reg == ST_LOAD_POST))
        else $error("divider finished outside a load state");
`endif

endmodule

FILE: sv/bmpdb_div.sv
`timescale 1ns / 1ps

module bmpdb_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [bmpdb_pkg::COL_W-1:0]         dividend,
    input  logic [bmpdb_pkg::STEP_W-1:0]        divisor,
    output bmpdb_pkg::div_res_t                 res
);

    logic [bmpdb_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                            done_reg, done_next;
    logic [bmpdb_pkg::COL_W-1:0]     quo_reg, quo_next;
    logic [bmpdb_pkg::PHASE_W-1:0]   rem_reg, rem_next;
    logic [bmpdb_pkg::STEP_W-1:0]    dvs_reg, dvs_next;
    logic [bmpdb_pkg::STEP_W-1:0]    trial;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[bmpdb_pkg::COL_W-1]};
        if (start) begin
            cnt_next = bmpdb_pkg::DIV_CNT_W'(bmpdb_pkg::DIV_STEPS);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == bmpdb_pkg::DIV_CNT_W'(1));
            if (trial >= dvs_reg) begin
                rem_next = bmpdb_pkg::PHASE_W'(trial - dvs_reg);
                quo_next = {quo_reg[bmpdb_pkg::COL_W-2:0], 1'b1};
            end else begin
                rem_next = trial[bmpdb_pkg::PHASE_W-1:0];
                quo_next = {quo_reg[bmpdb_pkg::COL_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign res.busy      = (cnt_reg != '0);
    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> ({1'b0, rem_reg} < dvs_reg))
        else $error("divider remainder not below divisor");
`endif

endmodule

FILE: sv/bmpdb_emit.sv
`timescale 1ns / 1ps

module bmpdb_emit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bmpdb_pkg::emit_req_t                req,
    input  logic [bmpdb_pkg::XO_W-1:0]          x_origin,
    input  logic [bmpdb_pkg::YO_W-1:0]          y_origin,
    output logic                                out_free,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bmpdb_pkg::PIX_W-1:0]         m_pixel_word,
    output logic [bmpdb_pkg::ADDR_W-1:0]        m_screen_address
);

    localparam int PROD_W = bmpdb_pkg::SIDE_W + bmpdb_pkg::ADDR_W;

    logic                           valid_reg;
    logic [bmpdb_pkg::PIX_W-1:0]    pix_reg;
    logic [bmpdb_pkg::ADDR_W-1:0]   addr_reg;
    logic [bmpdb_pkg::SIDE_W-1:0]   col_sum;
    logic [bmpdb_pkg::SIDE_W-1:0]   row_sum;
    logic                           on_screen;
    logic [PROD_W-1:0]              row_base;
    logic [bmpdb_pkg::ADDR_W-1:0]   addr_calc;

    // Place the pixel on the screen and clip
    always_comb begin
        col_sum   = bmpdb_pkg::SIDE_W'(req.target_column) + bmpdb_pkg::SIDE_W'(x_origin);
        row_sum   = bmpdb_pkg::SIDE_W'(req.target_row) + bmpdb_pkg::SIDE_W'(y_origin);
        on_screen = (col_sum < bmpdb_pkg::SIDE_W'(bmpdb_pkg::SCREEN_WIDTH)) &&
                    (row_sum < bmpdb_pkg::SIDE_W'(bmpdb_pkg::SCREEN_HEIGHT));
        row_base  = PROD_W'(row_sum) * PROD_W'(bmpdb_pkg::SCREEN_WIDTH);
        addr_calc = bmpdb_pkg::ADDR_W'(row_base + PROD_W'(col_sum));
    end

    assign out_free = !valid_reg || m_ready;

    // Hold the result until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (req.fire && on_screen && out_free) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
        if (req.fire && on_screen && out_free) begin
            pix_reg  <= req.pixel;
            addr_reg <= addr_calc;
        end
    end

    assign m_valid          = valid_reg;
    assign m_pixel_word     = pix_reg;
    assign m_screen_address = addr_reg;

`ifndef SYNTHESIS
    a_addr_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (addr_reg <
            bmpdb_pkg::ADDR_W'(bmpdb_pkg::SCREEN_WIDTH * bmpdb_pkg::SCREEN_HEIGHT)))
        else $error("screen address beyond framebuffer");
`endif

endmodule

FILE: dv/bmpdb_blit_checker.sv
`timescale 1ns / 1ps

module bmpdb_blit_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [bmpdb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bmpdb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [7:0]                          s_blue_byte,
    input  logic [7:0]                          s_green_byte,
    input  logic [7:0]                          s_red_byte,
    input  logic                                s_picture_start,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [bmpdb_pkg::PIX_W-1:0]         m_pixel_word,
    input  logic [bmpdb_pkg::ADDR_W-1:0]        m_screen_address,
    output int                                  mismatches,
    output int                                  outstanding
);
    import bmpdb_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [ADDR_W-1:0] address;
    } fb_write_t;

    // Framebuffer writes predicted but not yet seen on the result channel
    fb_write_t pending_writes[$];

    // Register copy
    logic [XO_W-1:0]    x_org;
    logic [YO_W-1:0]    y_org;
    logic [SIDE_W-1:0]  img_w;
    logic [SIDE_W-1:0]  img_h;
    logic [STEP_W-1:0]  shrink;

    // Position of the current source pixel
    logic [COL_W-1:0]   src_col;
    logic [COL_W-1:0]   rows_top;
    logic [COL_W-1:0]   tgt_col;
    logic [COL_W-1:0]   tgt_row;
    logic [PHASE_W-1:0] col_ph;
    logic [PHASE_W-1:0] row_ph;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // Picture side as the block uses it: zero reads as one, big values saturate
    function automatic int unsigned side_in_use(input logic [SIDE_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_IMAGE_SIDE) return MAX_IMAGE_SIDE;
        return v;
    endfunction

    function automatic int unsigned step_in_use(input logic [STEP_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_STEP) return MAX_STEP;
        return v;
    endfunction

    // Point the counters at the first pixel of the bottom file row
    function automatic void load_bottom_row();
        int unsigned last;
        int unsigned step;
        int unsigned quo;
        int unsigned rem;
        last     = side_in_use(img_h) - 1;
        step     = step_in_use(shrink);
        quo      = last / step;
        rem      = last % step;
        src_col  = '0;
        col_ph   = '0;
        tgt_col  = '0;
        rows_top = last[COL_W-1:0];
        row_ph   = rem[PHASE_W-1:0];
        tgt_row  = quo[COL_W-1:0];
    endfunction

    // Handle one source pixel: queue its framebuffer write if kept and on-screen
    function automatic void blit_pixel(input logic [7:0] blue, input logic [7:0] green,
                                       input logic [7:0] red, input logic start);
        int unsigned step;
        int unsigned width;
        int unsigned col;
        int unsigned row;
        int unsigned addr;
        int unsigned top_phase;
        fb_write_t   wr;
        if (start) load_bottom_row();
        step  = step_in_use(shrink);
        width = side_in_use(img_w);

        if (col_ph == '0 && row_ph == '0) begin
            col = tgt_col + x_org;
            row = tgt_row + y_org;
            if (col < SCREEN_WIDTH && row < SCREEN_HEIGHT) begin
                addr       = row * SCREEN_WIDTH + col;
                wr.pixel   = {red, green, blue};
                wr.address = addr[ADDR_W-1:0];
                pending_writes.push_back(wr);
            end
        end

        // Advance along the row, or step up one row, or wrap to a new picture
        if (src_col + 1 >= width) begin
            if (rows_top == '0) begin
                load_bottom_row();
            end else begin
                src_col  = '0;
                col_ph   = '0;
                tgt_col  = '0;
                rows_top = rows_top - 1'b1;
                if (row_ph == '0) begin
                    top_phase = step - 1;
                    row_ph    = top_phase[PHASE_W-1:0];
                    tgt_row   = tgt_row - 1'b1;
                end else begin
                    row_ph = row_ph - 1'b1;
                end
            end
        end else begin
            src_col = src_col + 1'b1;
            if (col_ph + 1 >= step) begin
                col_ph  = '0;
                tgt_col = tgt_col + 1'b1;
            end else begin
                col_ph = col_ph + 1'b1;
            end
        end
    endfunction

    always @(posedge aclk) begin : watch_p
        fb_write_t want;
        if (!aresetn) begin
            x_org    = '0;
            y_org    = '0;
            img_w    = SIDE_W'(SCREEN_WIDTH);
            img_h    = SIDE_W'(SCREEN_HEIGHT);
            shrink   = STEP_W'(1);
            src_col  = '0;
            rows_top = '0;
            tgt_col  = '0;
            tgt_row  = '0;
            col_ph   = '0;
            row_ph   = '0;
            pending_writes.delete();
        end else begin
            // Track register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_X_ORIGIN:      x_org  = cfg_wdata[XO_W-1:0];
                    REG_Y_ORIGIN:      y_org  = cfg_wdata[YO_W-1:0];
                    REG_IMAGE_WIDTH:   img_w  = cfg_wdata[SIDE_W-1:0];
                    REG_IMAGE_HEIGHT:  img_h  = cfg_wdata[SIDE_W-1:0];
                    REG_SHRINK_FACTOR: shrink = cfg_wdata[STEP_W-1:0];
                    default: ;
                endcase
            end

            // Compare a result transfer with the oldest prediction
            if (m_valid && m_ready) begin
                if (pending_writes.size() == 0) begin
                    $display("%0t: unexpected result: pixel_word %h screen_address %0d",
                             $time, m_pixel_word, m_screen_address);
                    mismatches = mismatches + 1;
                end else begin
                    want = pending_writes.pop_front();
                    if (m_pixel_word !== want.pixel) begin
                        $display("%0t: pixel_word mismatch: expected %h, actual %h",
                                 $time, want.pixel, m_pixel_word);
                        mismatches = mismatches + 1;
                    end
                    if (m_screen_address !== want.address) begin
                        $display("%0t: screen_address mismatch: expected %0d, actual %0d",
                                 $time, want.address, m_screen_address);
                        mismatches = mismatches + 1;
                    end
                end
            end

            // Predict from each accepted pixel
            if (s_valid && s_ready) begin
                blit_pixel(s_blue_byte, s_green_byte, s_red_byte, s_picture_start);
            end
        end
        outstanding = pending_writes.size();
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bmpdb_pkg::*;

    localparam int HALF_PERIOD      = 5;
    localparam int RESET_CYCLES     = 8;
    localparam int SETTLE_CYCLES    = 40;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int RANDOM_PIXELS    = 1050;
    localparam int MAX_FULL_PICTURE = 120;

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  cfg_wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata       = '0;
    logic                  s_valid         = 1'b0;
    logic [7:0]            s_blue_byte     = '0;
    logic [7:0]            s_green_byte    = '0;
    logic [7:0]            s_red_byte      = '0;
    logic                  s_picture_start = 1'b0;
    logic                  m_ready         = 1'b0;
    logic                  s_ready;
    logic                  m_valid;
    logic [PIX_W-1:0]      m_pixel_word;
    logic [ADDR_W-1:0]     m_screen_address;

    int mismatches;
    int outstanding;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int pixels_sent   = 0;
    int stall_cycles  = 0;
    int hold_left     = 0;
    bit hold_taken    = 1'b0;
    bit long_hold_req = 1'b0;

    always #HALF_PERIOD aclk = ~aclk;

    bmp_decimating_blit_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_blue_byte      (s_blue_byte),
        .s_green_byte     (s_green_byte),
        .s_red_byte       (s_red_byte),
        .s_picture_start  (s_picture_start),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pixel_word     (m_pixel_word),
        .m_screen_address (m_screen_address)
    );

    bmpdb_blit_checker blit_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_blue_byte      (s_blue_byte),
        .s_green_byte     (s_green_byte),
        .s_red_byte       (s_red_byte),
        .s_picture_start  (s_picture_start),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pixel_word     (m_pixel_word),
        .m_screen_address (m_screen_address),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    // Result side: one long hold-off on request, otherwise random backpressure
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (long_hold_req && !hold_taken) begin
            m_ready    <= 1'b0;
            hold_left  <= LONG_HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Abort when no transfer happens for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: watchdog: no transfer for %0d cycles", $time, stall_cycles);
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one pixel after a random gap and hold it until the transfer
    task automatic send_pixel(input logic [7:0] blue, input logic [7:0] green,
                              input logic [7:0] red, input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_blue_byte     <= blue;
        s_green_byte    <= green;
        s_red_byte      <= red;
        s_picture_start <= start;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        pixels_sent++;
    endtask

    // Send a run of random pixels, the first one optionally marking a picture start
    task automatic send_run(input int count, input bit first_start);
        for (int i = 0; i < count; i++) begin
            send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), first_start && (i == 0));
        end
    endtask

    // Drop valid, wait for every predicted write, then let the block settle
    task automatic wait_for_idle();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic program_registers(input int x, input int y, input int w,
                                     input int h, input int step);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_X_ORIGIN;
        cfg_wdata <= CFG_DATA_W'(x);
        @(negedge aclk);
        cfg_index <= REG_Y_ORIGIN;
        cfg_wdata <= CFG_DATA_W'(y);
        @(negedge aclk);
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_wdata <= CFG_DATA_W'(w);
        @(negedge aclk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_wdata <= CFG_DATA_W'(h);
        @(negedge aclk);
        cfg_index <= REG_SHRINK_FACTOR;
        cfg_wdata <= CFG_DATA_W'(step);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly small sides, sometimes up to the largest
    function automatic int pick_side();
        int r;
        r = $urandom_range(19);
        if (r == 0) return MAX_IMAGE_SIDE;
        if (r == 1) return $urandom_range(MAX_IMAGE_SIDE, 13);
        return $urandom_range(12, 1);
    endfunction

    // Register value for a side: sometimes the zero or oversized alias
    function automatic int side_register(input int side);
        if (side == 1 && $urandom_range(1) == 0) return 0;
        if (side == MAX_IMAGE_SIDE && $urandom_range(1) == 0) begin
            return $urandom_range((1 << SIDE_W) - 1, MAX_IMAGE_SIDE + 1);
        end
        return side;
    endfunction

    // Whole small pictures, truncated large ones, sometimes a missing start
    // or a few pixels that run past the end
    task automatic send_picture(input int pw, input int ph);
        int count;
        bit drop_start;
        count      = pw * ph;
        if (count > MAX_FULL_PICTURE) count = $urandom_range(60, 8);
        drop_start = ($urandom_range(7) == 0);
        send_run(count, !drop_start);
        if ($urandom_range(3) == 0) send_run($urandom_range(3, 1), 1'b0);
    endtask

    // Reprogram while idle, then stream a few pictures
    task automatic random_segment();
        int r;
        int x;
        int y;
        int step;
        int pw;
        int ph;
        wait_for_idle();
        r = $urandom_range(9);
        x = (r < 6) ? $urandom_range(60) : (r < 9) ? $urandom_range(799)
                                                   : $urandom_range(1023, 760);
        r = $urandom_range(9);
        y = (r < 6) ? $urandom_range(40) : (r < 9) ? $urandom_range(479)
                                                   : $urandom_range(511, 440);
        r = $urandom_range(19);
        step = (r == 0) ? 0 : (r == 1) ? $urandom_range(127, 65)
                        : (r == 2) ? $urandom_range(MAX_STEP, 5) : $urandom_range(4, 1);
        pw = pick_side();
        ph = pick_side();
        program_registers(x, y, side_register(pw), side_register(ph), step);
        repeat ($urandom_range(4, 1)) send_picture(pw, ph);
    endtask

    initial begin
        int random_base;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset registers, no picture start: the zero counters act as the top row
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'h5A, 8'hA5, 8'h3C, 1'b0);

        // Narrow mid-row: the top row ends at once and the counters reload,
        // then one full picture and one pixel past its end
        wait_for_idle();
        program_registers(0, 0, 2, 2, 1);
        send_run(6, 1'b0);

        // Bottom-right screen corner; the other pixels fall off-screen
        wait_for_idle();
        program_registers(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 3, 2, 1);
        send_run(6, 1'b1);

        // Zero side and step registers act as one
        wait_for_idle();
        program_registers(0, 0, 0, 0, 0);
        send_run(3, 1'b1);

        // Oversized sides and step, origin beyond the screen
        wait_for_idle();
        program_registers((1 << XO_W) - 1, (1 << YO_W) - 1, (1 << SIDE_W) - 1,
                          (1 << SIDE_W) - 1, (1 << STEP_W) - 1);
        send_run(2, 1'b1);

        // Largest step
        wait_for_idle();
        program_registers(5, 3, 3, 65, MAX_STEP);
        send_run(3, 1'b1);

        // Random pictures under three backpressure profiles; the result side
        // holds off for a long stretch at the start
        random_base = pixels_sent;
        long_hold_req <= 1'b1;
        for (int profile = 0; profile < 3; profile++) begin
            case (profile)
                0: begin
                    send_idle_pct = 30;
                    recv_idle_pct <= 75;
                end
                1: begin
                    send_idle_pct = 75;
                    recv_idle_pct <= 30;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            while (pixels_sent < random_base + (profile + 1) * RANDOM_PIXELS / 3) begin
                random_segment();
            end
        end

        wait_for_idle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
